[design/mrg_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mrg_pkg
// Shared types and constants of the motor reversal and encoder guard.
// ----------------------------------------------------------------------------
package mrg_pkg;

    localparam int RPM_W       = 16;
    localparam int BAND_W      = 15;
    localparam int COUNT_W     = 8;
    localparam int CFG_DATA_W  = 15;
    localparam int CFG_IDX_W   = 2;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // reset values of the configuration registers
    localparam logic [COUNT_W-1:0] BAD_TICK_LIMIT_RST  = 8'd10;
    localparam logic [BAND_W-1:0]  ZERO_SPEED_BAND_RST = 15'd50;
    localparam logic [COUNT_W-1:0] ZERO_TICK_LIMIT_RST = 8'd10;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BAD_TICK_LIMIT  = 2'd0,
        REG_ZERO_SPEED_BAND = 2'd1,
        REG_ZERO_TICK_LIMIT = 2'd2
    } cfg_idx_t;

    // item kinds
    localparam logic KIND_REQUEST = 1'b0;
    localparam logic KIND_TICK    = 1'b1;

    typedef struct packed {
        logic                    kind;
        logic signed [RPM_W-1:0] target_rpm;
        logic                    in_run;
        logic signed [RPM_W-1:0] shaft_rpm;
        logic                    encoder_fault;
    } item_t;

    typedef struct packed {
        logic signed [RPM_W-1:0] active_rpm;
        logic                    reversal_queued;
        logic                    encoder_lost;
        logic                    reversal_waiting;
    } result_t;

    typedef struct packed {
        logic [COUNT_W-1:0] bad_tick_limit;
        logic [BAND_W-1:0]  zero_speed_band;
        logic [COUNT_W-1:0] zero_tick_limit;
    } cfg_t;

    typedef struct packed {
        logic signed [RPM_W-1:0] command_rpm;
        logic signed [RPM_W-1:0] queued_rpm;
        logic                    reversal_flag;
        logic [COUNT_W-1:0]      bad_tick_count;
        logic [COUNT_W-1:0]      zero_tick_count;
    } state_t;

endpackage
`default_nettype wire

[design/mrg_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mrg_item_if / mrg_result_if
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface mrg_item_if;
    logic           valid;
    logic           ready;
    mrg_pkg::item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface mrg_result_if;
    logic             valid;
    logic             ready;
    mrg_pkg::result_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

[design/motor_reversal_and_encoder_guard.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// motor_reversal_and_encoder_guard
// Speed command guard: controlled reversals and encoder loss detection.
// ----------------------------------------------------------------------------
// Each accepted transaction (speed request or control tick) yields exactly one
// result. The item is captured in an input register, then one pass of compare
// and counter logic updates the guard state and loads the result register. One
// item is accepted every cycle; the only limit is the downstream ready, and one
// new item can still be captured in the input register while a finished result
// waits. Configuration writes take effect at once and are meant for idle
// periods; writes to an index past the last register are ignored.
module motor_reversal_and_encoder_guard (
    input  wire                            clk,
    input  wire                            rst_n,
    mrg_item_if.sink                       item,
    mrg_result_if.source                   result,
    input  wire                            cfg_we,
    input  wire [mrg_pkg::CFG_IDX_W-1:0]   cfg_idx,
    input  wire [mrg_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import mrg_pkg::*;

    cfg_t    cfg_reg;
    state_t  state_reg, state_next;
    logic    in_valid_reg;
    item_t   in_data_reg;
    logic    out_valid_reg;
    result_t out_data_reg, out_data_next;
    logic    advance;

    assign advance      = in_valid_reg && (!out_valid_reg || result.ready);
    assign item.ready   = !in_valid_reg || advance;
    assign result.valid = out_valid_reg;
    assign result.data  = out_data_reg;

    mrg_step u_step (
        .item (in_data_reg),
        .cur  (state_reg),
        .cfg  (cfg_reg),
        .nxt  (state_next),
        .res  (out_data_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.bad_tick_limit  <= BAD_TICK_LIMIT_RST;
            cfg_reg.zero_speed_band <= ZERO_SPEED_BAND_RST;
            cfg_reg.zero_tick_limit <= ZERO_TICK_LIMIT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx)
                REG_BAD_TICK_LIMIT:  cfg_reg.bad_tick_limit  <= cfg_data[COUNT_W-1:0];
                REG_ZERO_SPEED_BAND: cfg_reg.zero_speed_band <= cfg_data[BAND_W-1:0];
                REG_ZERO_TICK_LIMIT: cfg_reg.zero_tick_limit <= cfg_data[COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= '0;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (item.ready)
                in_valid_reg <= item.valid;
            if (advance)
            begin
                state_reg     <= state_next;
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (item.valid && item.ready)
            in_data_reg <= item.data;
        if (advance)
            out_data_reg <= out_data_next;
    end

`ifndef SYNTHESIS
    // a queued reversal holds the command at zero
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.reversal_flag |-> (state_reg.command_rpm == '0)
                                    && (state_reg.queued_rpm != '0))
        else $error("reversal queued with nonzero command or empty queue");

    // no queue means no stopped-tick count and no queued speed
    assert property (@(posedge clk) disable iff (!rst_n)
        !state_reg.reversal_flag |-> (state_reg.zero_tick_count == '0)
                                     && (state_reg.queued_rpm == '0))
        else $error("stale reversal state without a queued reversal");

    // a request that queues a reversal reports it waiting with zero command
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_data_reg.reversal_queued) |->
            out_data_reg.reversal_waiting && (out_data_reg.active_rpm == '0)
            && !out_data_reg.encoder_lost)
        else $error("inconsistent reversal result");

    // an advanced item always produces a result
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance) |=> out_valid_reg)
        else $error("advanced item did not produce a result");
`endif

endmodule
`default_nettype wire

[design/mrg_step.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mrg_step
// Next-state and result logic for one request or tick.
// ----------------------------------------------------------------------------
module mrg_step (
    input  wire mrg_pkg::item_t   item,
    input  wire mrg_pkg::state_t  cur,
    input  wire mrg_pkg::cfg_t    cfg,
    output mrg_pkg::state_t       nxt,
    output mrg_pkg::result_t      res
);
    import mrg_pkg::*;

    logic               cmd_pos, cmd_neg, req_pos, req_neg, shaft_pos, shaft_neg;
    logic               opp_cmd, opp_motion, apply_now;
    logic               bad, lost, stopped;
    logic [COUNT_W-1:0] bad_inc, zero_inc;
    logic [RPM_W-1:0]   shaft_mag;

    always_comb
    begin
        cmd_pos   = !cur.command_rpm[RPM_W-1] && (cur.command_rpm != '0);
        cmd_neg   = cur.command_rpm[RPM_W-1];
        req_pos   = !item.target_rpm[RPM_W-1] && (item.target_rpm != '0);
        req_neg   = item.target_rpm[RPM_W-1];
        shaft_pos = !item.shaft_rpm[RPM_W-1] && (item.shaft_rpm != '0);
        shaft_neg = item.shaft_rpm[RPM_W-1];

        opp_cmd    = (cmd_pos && req_neg) || (cmd_neg && req_pos);
        opp_motion = (shaft_pos && req_neg) || (shaft_neg && req_pos);
        apply_now  = !item.in_run || (item.target_rpm == '0)
                     || (!opp_cmd && !opp_motion);

        // two's complement negate; -32768 maps to 32768 unsigned
        shaft_mag = shaft_neg ? (~item.shaft_rpm + 1'b1) : item.shaft_rpm;
        stopped   = ({1'b0, cfg.zero_speed_band} >= shaft_mag);

        bad      = item.encoder_fault || (cur.command_rpm != '0 && item.shaft_rpm == '0);
        bad_inc  = (cur.bad_tick_count != COUNT_MAX) ? cur.bad_tick_count + 1'b1
                                                     : cur.bad_tick_count;
        lost     = bad && (bad_inc >= cfg.bad_tick_limit);
        zero_inc = (cur.zero_tick_count != COUNT_MAX) ? cur.zero_tick_count + 1'b1
                                                      : cur.zero_tick_count;

        nxt = cur;
        res = '0;

        if (item.kind == KIND_REQUEST)
        begin
            nxt.zero_tick_count = '0;
            if (apply_now)
            begin
                nxt.reversal_flag = 1'b0;
                nxt.queued_rpm    = '0;
                nxt.command_rpm   = item.target_rpm;
            end
            else
            begin
                nxt.reversal_flag   = 1'b1;
                nxt.queued_rpm      = item.target_rpm;
                nxt.command_rpm     = '0;
                res.reversal_queued = 1'b1;
            end
        end
        else
        begin
            nxt.bad_tick_count = bad ? bad_inc : '0;
            res.encoder_lost   = lost;
            // loss skips the reversal handling for this tick
            if (!lost && cur.reversal_flag)
            begin
                if (stopped)
                begin
                    nxt.zero_tick_count = zero_inc;
                    if (zero_inc >= cfg.zero_tick_limit)
                    begin
                        nxt.command_rpm     = cur.queued_rpm;
                        nxt.queued_rpm      = '0;
                        nxt.reversal_flag   = 1'b0;
                        nxt.zero_tick_count = '0;
                    end
                end
                else
                begin
                    nxt.zero_tick_count = '0;
                end
            end
        end

        res.active_rpm       = nxt.command_rpm;
        res.reversal_waiting = nxt.reversal_flag;
    end

endmodule
`default_nettype wire
